// ===== src/svie_pkg.sv =====
`timescale 1ns / 1ps

package svie_pkg;

  localparam logic [3:0] OP_ASSERT   = 4'd0;
  localparam logic [3:0] OP_PUSH     = 4'd1;
  localparam logic [3:0] OP_SIZE_RD  = 4'd2;
  localparam logic [3:0] OP_SIZE_SET = 4'd3;
  localparam logic [3:0] OP_ADD      = 4'd4;
  localparam logic [3:0] OP_SUB      = 4'd5;
  localparam logic [3:0] OP_STORE    = 4'd6;
  localparam logic [3:0] OP_LOAD     = 4'd7;
  localparam logic [3:0] OP_GT       = 4'd8;
  localparam logic [3:0] OP_GE       = 4'd9;
  localparam logic [3:0] OP_LT       = 4'd10;
  localparam logic [3:0] OP_LE       = 4'd11;
  localparam logic [3:0] OP_EQ       = 4'd12;
  localparam logic [3:0] OP_SELECT   = 4'd13;
  localparam logic [3:0] OP_GOTO     = 4'd14;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ASSERT_FAIL = 3'd1;
  localparam logic [2:0] ST_UNKNOWN_OP  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW    = 3'd4;
  localparam logic [2:0] ST_BAD_HEAP    = 3'd5;

  typedef struct packed {
    logic [1:0] pops;
    logic       push;
    logic       is_heap;
    logic       is_store;
    logic       is_size_set;
    logic       is_goto;
    logic       unknown;
    logic       assert_fail;
  } svie_dec_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ===== src/svie_stack_ram.sv =====
`timescale 1ns / 1ps

module svie_stack_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/svie_heap_ram.sv =====
`timescale 1ns / 1ps

module svie_heap_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  output logic [63:0]   rd_data_o,
  output logic          busy_o
);

  logic [63:0]   mem [DEPTH];
  logic [63:0]   rd_data_q;
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

// ===== src/svie_alu.sv =====
`timescale 1ns / 1ps

module svie_alu
  import svie_pkg::*;
(
  input  logic [3:0]  op_i,
  input  logic [63:0] arg1_i,
  input  logic [63:0] arg2_i,
  input  logic [63:0] tos_i,
  input  logic [63:0] nos_i,
  input  logic [63:0] heap_i,
  input  logic [63:0] size_i,
  output svie_dec_t   dec_o,
  output logic [63:0] res_o
);

  logic [63:0] a;
  logic        a_lt;
  logic        arg_lt;

  assign a      = sext32(tos_i[31:0]);
  assign a_lt   = $signed(a) < $signed(arg1_i);
  assign arg_lt = $signed(arg1_i) < $signed(a);

  always_comb begin
    dec_o             = '0;
    res_o             = '0;
    dec_o.assert_fail = (a != arg1_i);
    case (op_i)
      OP_ASSERT:   dec_o.pops = 2'd1;
      OP_PUSH: begin
        dec_o.push = 1'b1;
        res_o      = arg1_i;
      end
      OP_SIZE_RD: begin
        dec_o.push = 1'b1;
        res_o      = size_i;
      end
      OP_SIZE_SET: begin
        dec_o.pops        = 2'd1;
        dec_o.is_size_set = 1'b1;
      end
      OP_ADD: begin
        dec_o.pops = 2'd2;
        dec_o.push = 1'b1;
        res_o      = sext32(nos_i[31:0] + tos_i[31:0]);
      end
      OP_SUB: begin
        dec_o.pops = 2'd2;
        dec_o.push = 1'b1;
        res_o      = sext32(nos_i[31:0] - tos_i[31:0]);
      end
      OP_STORE: begin
        dec_o.pops     = 2'd1;
        dec_o.is_heap  = 1'b1;
        dec_o.is_store = 1'b1;
      end
      OP_LOAD: begin
        dec_o.push    = 1'b1;
        dec_o.is_heap = 1'b1;
        res_o         = sext32(heap_i[31:0]);
      end
      OP_GT: begin
        dec_o.pops = 2'd1;
        dec_o.push = 1'b1;
        res_o      = {63'd0, arg_lt};
      end
      OP_GE: begin
        dec_o.pops = 2'd1;
        dec_o.push = 1'b1;
        res_o      = {63'd0, !a_lt};
      end
      OP_LT: begin
        dec_o.pops = 2'd1;
        dec_o.push = 1'b1;
        res_o      = {63'd0, a_lt};
      end
      OP_LE: begin
        dec_o.pops = 2'd1;
        dec_o.push = 1'b1;
        res_o      = {63'd0, !arg_lt};
      end
      OP_EQ: begin
        dec_o.pops = 2'd1;
        dec_o.push = 1'b1;
        res_o      = {63'd0, (a == arg1_i)};
      end
      OP_SELECT: begin
        dec_o.pops = 2'd1;
        dec_o.push = 1'b1;
        res_o      = (tos_i[31:0] != 32'd0) ? arg1_i : arg2_i;
      end
      OP_GOTO:     dec_o.is_goto = 1'b1;
      default:     dec_o.unknown = 1'b1;
    endcase
  end

endmodule

// ===== src/stack_vm_instruction_execute.sv =====
`timescale 1ns / 1ps

// Stack machine executor, one instruction per transfer.
// Input stream: tuser = opcode[3:0]; tdata = arg_first, arg_second.
// Output stream, one transfer per instruction: tdata = next_offset, top_value;
// tlast = halted; tuser = status.
// APB port: register 0 (byte address 0) is program_length, write only while
// the block is idle.
// The input stage registers each transfer and the output stage its result.
// Throughput: one instruction per cycle unless the output stalls or the heap
// is being cleared. The two top stack entries and the entry under them sit in
// registers; the rest spills to a one-port-read stack memory addressed from
// next-cycle depth. Heap reads start at input transfer so the load data is
// registered when the instruction executes.
// Reset: depth, offset, size register and program_length clear; the heap is
// then zeroed one entry per cycle, with s_axis_tready low.
// A stalled output holds its result; the input stage fills once more, then
// s_axis_tready drops until the output drains.
module stack_vm_instruction_execute
  import svie_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int HEAP_DEPTH  = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // arg_first[63:0], arg_second[127:64]
  input  logic [3:0]    s_axis_tuser,  // opcode[3:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [79:0]   m_axis_tdata,  // next_offset[15:0], top_value[79:16]
  output logic          m_axis_tlast,
  output logic [2:0]    m_axis_tuser,  // status[2:0]
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int HAW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

  logic          a_valid_q;
  logic [3:0]    a_op_q;
  logic [63:0]   a_arg1_q, a_arg2_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   tos_q, tos_d;
  logic [63:0]   nos_q, nos_d;
  logic [63:0]   size_q, size_d;
  logic [15:0]   pc_q, pc_d;
  logic [15:0]   len_q;

  logic          o_valid_q;
  logic [15:0]   o_next_q;
  logic [63:0]   o_top_q;
  logic          o_halt_q;
  logic [2:0]    o_status_q;

  logic          fire, s_acc, heap_busy;
  logic [63:0]   third, heap_rd, res;
  svie_dec_t     dec;
  logic          halted_now, uf, of, bh, do_ok;
  logic [2:0]    status;
  logic          stk_we, heap_we;
  logic [CW-1:0] spill_addr, fill_addr;

  assign fire          = a_valid_q && (!o_valid_q || m_axis_tready);
  assign s_axis_tready = !heap_busy && (!a_valid_q || fire);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  svie_alu u_alu (
    .op_i   (a_op_q),
    .arg1_i (a_arg1_q),
    .arg2_i (a_arg2_q),
    .tos_i  (tos_q),
    .nos_i  (nos_q),
    .heap_i (heap_rd),
    .size_i (size_q),
    .dec_o  (dec),
    .res_o  (res)
  );

  assign halted_now = (pc_q >= len_q);
  assign uf         = (cnt_q < CW'(dec.pops));
  assign of         = dec.push && (dec.pops == 2'd0) && (cnt_q == CW'(STACK_DEPTH));
  assign bh         = dec.is_heap && (a_arg1_q >= 64'(HEAP_DEPTH));

  always_comb begin
    if (dec.unknown)          status = ST_UNKNOWN_OP;
    else if (uf)              status = ST_UNDERFLOW;
    else if (of)              status = ST_OVERFLOW;
    else if (bh)              status = ST_BAD_HEAP;
    else if (dec.pops == 2'd1 && !dec.push && !dec.is_size_set && !dec.is_store
             && dec.assert_fail)
                              status = ST_ASSERT_FAIL;
    else                      status = ST_OK;
  end

  assign do_ok = fire && !halted_now && !dec.unknown && !uf && !of && !bh;

  always_comb begin
    cnt_d  = cnt_q;
    tos_d  = tos_q;
    nos_d  = nos_q;
    size_d = size_q;
    pc_d   = pc_q;
    if (fire && !halted_now) begin
      pc_d = pc_q + ((do_ok && dec.is_goto) ? a_arg1_q[15:0] : 16'd0) + 16'd1;
    end
    if (do_ok) begin
      if (dec.is_size_set) begin
        size_d = tos_q;
      end
      if (dec.push) begin
        tos_d = res;
        case (dec.pops)
          2'd0: begin
            nos_d = tos_q;
            cnt_d = cnt_q + CW'(1);
          end
          2'd2: begin
            nos_d = third;
            cnt_d = cnt_q - CW'(1);
          end
          default: ;
        endcase
      end else if (dec.pops == 2'd1) begin
        tos_d = nos_q;
        nos_d = third;
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  assign stk_we     = do_ok && dec.push && (dec.pops == 2'd0) && (cnt_q >= CW'(2));
  assign spill_addr = cnt_q - CW'(2);
  assign fill_addr  = cnt_d - CW'(3);

  svie_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (SAW)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (stk_we),
    .wr_addr_i (spill_addr[SAW-1:0]),
    .wr_data_i (nos_q),
    .rd_addr_i (fill_addr[SAW-1:0]),
    .rd_data_o (third)
  );

  assign heap_we = do_ok && dec.is_store;

  svie_heap_ram #(
    .DEPTH (HEAP_DEPTH),
    .AW    (HAW)
  ) u_heap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_acc),
    .rd_addr_i (s_axis_tdata[HAW-1:0]),
    .wr_en_i   (heap_we),
    .wr_addr_i (a_arg1_q[HAW-1:0]),
    .wr_data_i (sext32(tos_q[31:0])),
    .rd_data_o (heap_rd),
    .busy_o    (heap_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      cnt_q     <= '0;
      size_q    <= '0;
      pc_q      <= '0;
      len_q     <= '0;
    end else begin
      if (s_acc)          a_valid_q <= 1'b1;
      else if (fire)      a_valid_q <= 1'b0;
      if (fire)           o_valid_q <= 1'b1;
      else if (m_axis_tready) o_valid_q <= 1'b0;
      cnt_q  <= cnt_d;
      size_q <= size_d;
      pc_q   <= pc_d;
      if (psel && penable && pwrite) begin
        len_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    nos_q <= nos_d;
    if (s_acc) begin
      a_op_q   <= s_axis_tuser;
      a_arg1_q <= s_axis_tdata[63:0];
      a_arg2_q <= s_axis_tdata[127:64];
    end
    if (fire) begin
      o_next_q   <= pc_d;
      o_top_q    <= (cnt_d != '0) ? tos_d : 64'd0;
      o_halt_q   <= (pc_d >= len_q);
      o_status_q <= halted_now ? ST_OK : status;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_top_q, o_next_q};
  assign m_axis_tlast  = o_halt_q;
  assign m_axis_tuser  = o_status_q;

  // single register; paddr carries only the byte offset within it
  assign prdata = {16'd0, len_q} | {30'd0, paddr & 2'b00};
  assign pready = 1'b1;

endmodule

// ===== src/svie_checker.sv =====
`timescale 1ns / 1ps

module svie_checker
  import svie_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_BAD_HEAP))
    else $error("status code out of range");

  a_len_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> (prdata[15:0] == $past(pwdata[15:0])))
    else $error("program length readback mismatch");

  a_len_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> (prdata[31:16] == 16'd0))
    else $error("program length upper bits set");

endmodule

bind stack_vm_instruction_execute svie_checker u_svie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import svie_pkg::*;

  localparam int STACK_DEPTH = 256;
  localparam int HEAP_DEPTH  = 256;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [3:0] OP_UNKNOWN   = 4'd15;
  localparam logic [1:0] REG_PROG_LEN = 2'd0;

  localparam logic [63:0] W_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] W_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] W_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] next_off;
    logic [63:0] top;
    logic        halted;
    logic [2:0]  status;
  } vm_result_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] a1;
    logic [63:0] a2;
    logic        has_want;
    vm_result_t  want;
  } instr_row_t;

  localparam vm_result_t NO_WANT = '0;
  localparam vm_result_t HALT0   = {16'd0, 64'd0, 1'b1, ST_OK};
  localparam int N_DIR = 28;

  localparam instr_row_t DIR_ROWS [N_DIR] = '{
    {OP_PUSH,     64'd5,      64'd0, 1'b1, HALT0},
    {OP_GOTO,     64'd100,    64'd0, 1'b1, HALT0},
    {OP_ADD,      64'd0,      64'd0, 1'b1, {16'd1, 64'd0, 1'b0, ST_UNDERFLOW}},
    {OP_PUSH,     W_MAX,      64'd0, 1'b1, {16'd2, W_MAX, 1'b0, ST_OK}},
    {OP_PUSH,     W_MIN,      64'd0, 1'b1, {16'd3, W_MIN, 1'b0, ST_OK}},
    {OP_ADD,      64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_PUSH,     64'd1,      64'd0, 1'b0, NO_WANT},
    {OP_SUB,      64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_PUSH,     64'h7FFF_FFFF, 64'd0, 1'b0, NO_WANT},
    {OP_PUSH,     64'd1,      64'd0, 1'b0, NO_WANT},
    {OP_ADD,      64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_SIZE_SET, 64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_SIZE_RD,  64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_STORE,    64'd255,    64'd0, 1'b0, NO_WANT},
    {OP_LOAD,     64'd255,    64'd0, 1'b0, NO_WANT},
    {OP_STORE,    64'd256,    64'd0, 1'b0, NO_WANT},
    {OP_LOAD,     W_NEG1,     64'd0, 1'b0, NO_WANT},
    {OP_GT,       W_MIN,      64'd0, 1'b0, NO_WANT},
    {OP_GE,       64'd1,      64'd0, 1'b0, NO_WANT},
    {OP_LT,       W_MAX,      64'd0, 1'b0, NO_WANT},
    {OP_LE,       64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_EQ,       64'd1,      64'd0, 1'b0, NO_WANT},
    {OP_SELECT,   W_MAX,      W_MIN, 1'b0, NO_WANT},
    {OP_ASSERT,   W_MIN,      64'd0, 1'b0, NO_WANT},
    {OP_UNKNOWN,  64'd0,      64'd0, 1'b0, NO_WANT},
    {OP_GOTO,     W_NEG1,     64'd0, 1'b0, NO_WANT},
    {OP_GOTO,     64'h0000_0001_0000_0005, 64'd0, 1'b0, NO_WANT},
    {OP_ASSERT,   64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0, NO_WANT}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata;   // arg_first[63:0], arg_second[127:64]
  logic [3:0]    s_axis_tuser;   // opcode[3:0]
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [79:0]   m_axis_tdata;   // next_offset[15:0], top_value[79:16]
  logic          m_axis_tlast;
  logic [2:0]    m_axis_tuser;   // status[2:0]
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [1:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  // machine state mirror
  logic [63:0] op_stack [STACK_DEPTH];
  logic [63:0] heap_mem [HEAP_DEPTH];
  int          stk_depth;
  logic [63:0] size_reg;
  logic [15:0] pc_offset;
  logic [15:0] prog_len;

  vm_result_t  expected_q [$];
  vm_result_t  head_result;
  int          mismatches;
  int          instr_count;
  int          result_count;
  int          cfg_writes;
  int          status_hits [8];
  int          idle_cycles;
  int          tx_idle_pct;
  int          rx_stall_pct;
  bit          let_halt;
  bit          fill_mode;

  stack_vm_instruction_execute #(
    .STACK_DEPTH(STACK_DEPTH),
    .HEAP_DEPTH (HEAP_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] sign_ext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic vm_result_t execute_instr(input logic [3:0] op, input logic [63:0] a1,
                                               input logic [63:0] a2);
    vm_result_t  r;
    int          pops;
    int          pushes;
    logic [63:0] raw;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] res;
    logic [63:0] delta;
    r = '0;
    r.status = ST_OK;
    if (pc_offset >= prog_len) begin
      r.next_off = pc_offset;
    end else begin
      pops = 0;
      pushes = 0;
      delta = '0;
      case (op)
        OP_ASSERT, OP_SIZE_SET, OP_STORE: pops = 1;
        OP_GT, OP_GE, OP_LT, OP_LE, OP_EQ, OP_SELECT: begin
          pops = 1;
          pushes = 1;
        end
        OP_ADD, OP_SUB: begin
          pops = 2;
          pushes = 1;
        end
        OP_PUSH, OP_SIZE_RD, OP_LOAD: pushes = 1;
        default: ;
      endcase
      if (op == OP_UNKNOWN) begin
        r.status = ST_UNKNOWN_OP;
      end else if (stk_depth < pops) begin
        r.status = ST_UNDERFLOW;
      end else if (stk_depth - pops + pushes > STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else if ((op == OP_STORE || op == OP_LOAD) && a1 >= 64'(HEAP_DEPTH)) begin
        r.status = ST_BAD_HEAP;
      end else begin
        raw = (pops >= 1) ? op_stack[stk_depth-1] : 64'd0;
        a = sign_ext32(raw[31:0]);
        b = (pops == 2) ? sign_ext32(op_stack[stk_depth-2][31:0]) : 64'd0;
        stk_depth -= pops;
        res = '0;
        case (op)
          OP_ASSERT:   if (a != a1) r.status = ST_ASSERT_FAIL;
          OP_PUSH:     res = a1;
          OP_SIZE_RD:  res = size_reg;
          OP_SIZE_SET: size_reg = raw;
          OP_ADD:      res = sign_ext32(b[31:0] + a[31:0]);
          OP_SUB:      res = sign_ext32(b[31:0] - a[31:0]);
          OP_STORE:    heap_mem[a1[7:0]] = a;
          OP_LOAD:     res = sign_ext32(heap_mem[a1[7:0]][31:0]);
          OP_GT:       res = {63'd0, $signed(a1) < $signed(a)};
          OP_GE:       res = {63'd0, !($signed(a) < $signed(a1))};
          OP_LT:       res = {63'd0, $signed(a) < $signed(a1)};
          OP_LE:       res = {63'd0, !($signed(a1) < $signed(a))};
          OP_EQ:       res = {63'd0, a == a1};
          OP_SELECT:   res = (a != 0) ? a1 : a2;
          default:     delta = a1;
        endcase
        if (pushes != 0) begin
          op_stack[stk_depth] = res;
          stk_depth++;
        end
      end
      pc_offset = pc_offset + delta[15:0] + 16'd1;
      r.next_off = pc_offset;
    end
    r.top = (stk_depth != 0) ? op_stack[stk_depth-1] : 64'd0;
    r.halted = (r.next_off >= prog_len);
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {32'd0, 32'($urandom_range(0, 16))} - 64'd8;
      2: return W_MAX;
      3: return W_MIN;
      4: return sign_ext32($urandom);
      default: return sign_ext32($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
    endcase
  endfunction

  // goto delta landing on a target in [0, hi]; upper bits are don't-care
  function automatic logic [63:0] goto_delta(input int hi);
    logic [15:0] low;
    logic [63:0] upper;
    low = 16'($urandom_range(0, (hi < 0) ? 0 : hi)) - pc_offset - 16'd1;
    upper = {$urandom, $urandom};
    return {upper[63:16], low};
  endfunction

  task automatic pick_instr(output logic [3:0] op, output logic [63:0] a1,
                            output logic [63:0] a2);
    logic [63:0] top_sx;
    top_sx = (stk_depth != 0) ? sign_ext32(op_stack[stk_depth-1][31:0]) : 64'd0;
    a1 = rand_word();
    a2 = rand_word();
    if (!let_halt && int'(pc_offset) + 2 >= int'(prog_len)) begin
      op = OP_GOTO;
      a1 = goto_delta(int'(prog_len) - 2);
    end else if (fill_mode) begin
      // keep pushing until one push past a full stack
      op = OP_PUSH;
      if (stk_depth == STACK_DEPTH) fill_mode = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      op = 4'($urandom_range(0, 15));
      a1 = {$urandom, $urandom};
      a2 = {$urandom, $urandom};
      if (op == OP_GOTO && !let_halt) a1 = goto_delta(int'(prog_len) - 2);
    end else begin
      if (stk_depth < 2 || (stk_depth < 192 && $urandom_range(0, 3) == 0))
        op = OP_PUSH;
      else
        op = 4'($urandom_range(0, 14));
      case (op)
        OP_ASSERT: if ($urandom_range(0, 2) != 0) a1 = top_sx;
        OP_STORE, OP_LOAD: begin
          if ($urandom_range(0, 9) != 0) a1 = 64'($urandom_range(0, HEAP_DEPTH - 1));
        end
        OP_GT, OP_GE, OP_LT, OP_LE, OP_EQ: begin
          if ($urandom_range(0, 1) != 0) a1 = top_sx + 64'($urandom_range(0, 2)) - 64'd1;
        end
        OP_GOTO: if (!let_halt) a1 = goto_delta(int'(prog_len) - 2);
        default: ;
      endcase
    end
  endtask

  task automatic issue(input logic [3:0] op, input logic [63:0] a1, input logic [63:0] a2,
                       input logic has_want, input vm_result_t want);
    vm_result_t r;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {a2, a1};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = execute_instr(op, a1, a2);
    expected_q.push_back(has_want ? want : r);
    instr_count++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_PROG_LEN) prog_len = data[15:0];
    cfg_writes++;
  endtask

  task automatic run_phase(input int plen, input int n_instr, input int tx_pct,
                           input int rx_pct, input bit fill, input bit halt_ok);
    logic [3:0]  op;
    logic [63:0] a1;
    logic [63:0] a2;
    wait_idle();
    apb_write(REG_PROG_LEN, 32'(plen));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    let_halt     = halt_ok;
    fill_mode    = fill;
    for (int i = 0; i < n_instr; i++) begin
      pick_instr(op, a1, a2);
      issue(op, a1, a2, 1'b0, NO_WANT);
    end
    // park the offset low so the next program length still runs
    if (!let_halt && pc_offset < prog_len)
      issue(OP_GOTO, goto_delta(99), rand_word(), 1'b0, NO_WANT);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected: %h status %0d", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        head_result = expected_q.pop_front();
        check_field("next_offset", 64'(head_result.next_off), 64'(m_axis_tdata[15:0]));
        check_field("top_value", head_result.top, m_axis_tdata[79:16]);
        check_field("halted", 64'(head_result.halted), 64'(m_axis_tlast));
        check_field("status", 64'(head_result.status), 64'(m_axis_tuser));
        status_hits[head_result.status]++;
        result_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_cycles   = 0;
    mismatches    = 0;
    instr_count   = 0;
    result_count  = 0;
    cfg_writes    = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    let_halt      = 1'b0;
    fill_mode     = 1'b0;
    stk_depth     = 0;
    size_reg      = '0;
    pc_offset     = '0;
    prog_len      = '0;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    foreach (op_stack[i]) op_stack[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_write(REG_PROG_LEN, 32'd0);

    for (int i = 0; i < N_DIR; i++) begin
      if (i == 2) begin
        wait_idle();
        apb_write(REG_PROG_LEN, 32'hFFFF);
      end
      issue(DIR_ROWS[i].op, DIR_ROWS[i].a1, DIR_ROWS[i].a2, DIR_ROWS[i].has_want,
            DIR_ROWS[i].want);
    end

    run_phase(65535, 300, 0, 0, 1'b1, 1'b0);
    run_phase(1000, 250, 75, 0, 1'b0, 1'b0);
    run_phase(65535, 300, 0, 75, 1'b1, 1'b0);
    run_phase(300, 250, 12, 12, 1'b0, 1'b0);
    run_phase(int'(pc_offset) + 20, 60, 0, 0, 1'b0, 1'b1);
    run_phase(65535, 200, 12, 12, 1'b0, 1'b0);

    wait_idle();
    $display("tb: %0d instructions, %0d results checked, %0d program-length writes",
             instr_count, result_count, cfg_writes);
    $display("tb: status ok %0d, assert %0d, unknown %0d, underflow %0d, overflow %0d, heap %0d",
             status_hits[ST_OK], status_hits[ST_ASSERT_FAIL], status_hits[ST_UNKNOWN_OP],
             status_hits[ST_UNDERFLOW], status_hits[ST_OVERFLOW], status_hits[ST_BAD_HEAP]);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== stack_vm_instruction_execute.f =====
src/svie_pkg.sv
src/svie_stack_ram.sv
src/svie_heap_ram.sv
src/svie_alu.sv
src/stack_vm_instruction_execute.sv
src/svie_checker.sv
tb/tb.sv
